// ----- design/window_gradient_engine_defines.svh -----
// Assertion macros for the gradient engine checker
`ifndef WINDOW_GRADIENT_ENGINE_DEFINES_SVH
`define WINDOW_GRADIENT_ENGINE_DEFINES_SVH

`define WGE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wge check failed");

`define WGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wge check failed");

`endif

// ----- design/wge_pkg.sv -----
package wge_pkg;

  localparam int MAX_ROWS       = 64;
  localparam int MAX_COLS       = 64;
  localparam int MAX_HALF_WIDTH = 8;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int CNT_W  = $clog2((2 * MAX_HALF_WIDTH + 1) * (2 * MAX_HALF_WIDTH + 1) + 1);
  localparam int DVD_W  = 66;
  localparam int DVS_W  = 49;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = 3'd5;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;
  localparam logic MODE_MINMAX = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic signed [31:0] base_in;
    logic signed [31:0] value_in;
    logic              base_present;
    logic              value_present;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic signed [31:0] gradient;
    logic               used_fallback;
    logic               gradient_missing;
  } out_item_t;

  typedef struct packed {
    logic               bv;
    logic               vv;
    logic signed [31:0] base;
    logic signed [31:0] value;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  function automatic logic signed [31:0] sat32(input logic signed [DVD_W:0] v);
    logic signed [DVD_W:0] hi;
    logic signed [DVD_W:0] lo;
    hi = (DVD_W+1)'(32'sh7FFF_FFFF);
    lo = ~hi;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

// ----- design/wge_ram.sv -----
module wge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/wge_div.sv -----
module wge_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [wge_pkg::DVD_W-1:0]   dvd,
  input  logic signed [wge_pkg::DVS_W-1:0]   dvs,
  output logic                               done,
  output logic signed [wge_pkg::DVD_W:0]     quot
);
  import wge_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  q;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs_mag;
  logic              neg;
  logic              running;
  logic [STEP_W-1:0] step;
  logic [DVS_W:0]    sh;
  logic [DVS_W:0]    diff;
  logic              take;

  assign sh   = {rem, q[DVD_W-1]};
  assign diff = sh - {1'b0, dvs_mag};
  assign take = sh >= {1'b0, dvs_mag};
  assign quot = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        q       <= dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);
        dvs_mag <= dvs[DVS_W-1] ? DVS_W'(-dvs) : DVS_W'(dvs);
        neg     <= dvd[DVD_W-1] ^ dvs[DVS_W-1];
        rem     <= '0;
      end else if (running) begin
        rem  <= take ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
        q    <= {q[DVD_W-2:0], take};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/window_gradient_engine.sv -----
// channel  | signals                                   | transfer when
// command  | start, busy, cmd                          | start && !busy
// result   | done, res                                 | done (one cycle, no stall)
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
// A write goes straight to the cell memory. A compute reads one window cell per cycle from the cell
// memory, then runs a shift-subtract divider: min-max mode divides at most once, regression
// mode up to 5 times.
// Reset clears control state only; cell memory is undefined until written.
// The result strobe cannot be stalled; busy falls in the same cycle as the strobe is shown.
module window_gradient_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  wge_pkg::in_item_t                    cmd,
  output logic                                 done,
  output wge_pkg::out_item_t                   res,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wge_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);
  import wge_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WALK, ST_DRAIN, ST_DECIDE, ST_DIV_MX, ST_DIV_MY,
    ST_DIV_MXX, ST_DIV_MXY, ST_MUL, ST_FINISH, ST_DIV_GRAD
  } state_t;

  state_t state;

  logic               mode;
  logic [6:0]         grid_rows;
  logic [6:0]         grid_cols;
  logic [3:0]         half_width;
  logic [30:0]        min_spread;
  logic signed [31:0] fallback;

  logic [6:0] rows_c, cols_c;
  logic [3:0] hw_c;
  logic [6:0] rsum, csum, rlim, clim;
  logic [ROW_W-1:0] r0_next, r1_next;
  logic [COL_W-1:0] c0_next, c1_next;
  logic acc, in_grid;

  logic [ROW_W-1:0] tgt_row, r, r0, r1;
  logic [COL_W-1:0] tgt_col, c, c0, c1;
  logic             rd_issue, last_issue;

  cell_t ram_wdata, rd_cell;
  logic  v1, l1, v2, l2;
  logic signed [31:0] x_d, y_d;
  logic               bv_d, vv_d;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] pxx, pxy;
  logic signed [47:0] fxx, fxy;

  logic               any;
  logic signed [31:0] bmax, bmin, vmax, vmin;
  logic [CNT_W-1:0]   nx, ny, nxy;
  logic signed [40:0] sx, sy;
  logic signed [57:0] sxx, sxy;
  logic signed [31:0] mx, my;
  logic signed [47:0] mxx, mxy;
  logic signed [32:0] spread, vdiff;
  logic signed [48:0] den, num;

  logic                     div_start, div_done;
  logic signed [DVD_W-1:0]  div_dvd;
  logic signed [DVS_W-1:0]  div_dvs;
  logic signed [DVD_W:0]    quot;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign acc       = start && !busy;

  assign rows_c = (grid_rows == 7'd0) ? 7'd1 :
                  (grid_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : grid_rows;
  assign cols_c = (grid_cols == 7'd0) ? 7'd1 :
                  (grid_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : grid_cols;
  assign hw_c   = (half_width == 4'd0) ? 4'd1 :
                  (half_width > 4'(MAX_HALF_WIDTH)) ? 4'(MAX_HALF_WIDTH) : half_width;

  assign in_grid = ({1'b0, cmd.row} < rows_c) && ({1'b0, cmd.col} < cols_c);
  assign rsum    = {1'b0, cmd.row} + {3'b0, hw_c};
  assign csum    = {1'b0, cmd.col} + {3'b0, hw_c};
  assign rlim    = rows_c - 7'd1;
  assign clim    = cols_c - 7'd1;
  assign r0_next = (cmd.row > ROW_W'(hw_c)) ? cmd.row - ROW_W'(hw_c) : '0;
  assign c0_next = (cmd.col > COL_W'(hw_c)) ? cmd.col - COL_W'(hw_c) : '0;
  assign r1_next = (rsum < rlim) ? rsum[ROW_W-1:0] : rlim[ROW_W-1:0];
  assign c1_next = (csum < clim) ? csum[COL_W-1:0] : clim[COL_W-1:0];

  assign ram_wdata  = '{bv: cmd.base_present, vv: cmd.value_present,
                        base: cmd.base_in, value: cmd.value_in};
  assign rd_issue   = (state == ST_WALK);
  assign last_issue = (r == r1) && (c == c1);

  wge_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_cells (
    .clk   (clk),
    .we    (acc && cmd.opcode == OP_WRITE),
    .waddr ({cmd.row, cmd.col}),
    .wdata (ram_wdata),
    .raddr ({r, c}),
    .rdata (rd_cell)
  );

  wge_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quot  (quot)
  );

  assign mul_a  = (state == ST_MUL) ? mx : rd_cell.base;
  assign mul_b  = (state == ST_MUL) ? my : rd_cell.value;
  assign fxx    = pxx[63:16];
  assign fxy    = pxy[63:16];
  assign spread = 33'(bmax) - 33'(bmin);
  assign vdiff  = 33'(vmax) - 33'(vmin);
  assign den    = 49'(mxx) - 49'(fxx);
  assign num    = 49'(mxy) - 49'(fxy);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      grid_rows  <= 7'd64;
      grid_cols  <= 7'd64;
      half_width <= 4'd1;
      min_spread <= '0;
      fallback   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:     mode       <= cfg_data[0];
        REG_ROWS:     grid_rows  <= cfg_data[6:0];
        REG_COLS:     grid_cols  <= cfg_data[6:0];
        REG_HALF:     half_width <= cfg_data[3:0];
        REG_SPREAD:   min_spread <= cfg_data[30:0];
        REG_FALLBACK: fallback   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= rd_issue;
      v2 <= v1;
    end
    l1 <= last_issue;
    l2 <= l1;
    if (v1) begin
      x_d  <= rd_cell.base;
      y_d  <= rd_cell.value;
      bv_d <= rd_cell.bv;
      vv_d <= rd_cell.vv;
    end
    if (v1 || state == ST_MUL) begin
      pxx <= mul_a * mul_a;
      pxy <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;

      if (v2) begin
        if (bv_d && vv_d) begin
          if (!any || x_d > bmax) begin
            bmax <= x_d;
            vmax <= y_d;
          end
          if (!any || x_d < bmin) begin
            bmin <= x_d;
            vmin <= y_d;
          end
          any <= 1'b1;
          nxy <= nxy + CNT_W'(1);
          sxy <= sxy + 58'(fxy);
        end
        if (bv_d) begin
          nx  <= nx + CNT_W'(1);
          sx  <= sx + 41'(x_d);
          sxx <= sxx + 58'(fxx);
        end
        if (vv_d) begin
          ny <= ny + CNT_W'(1);
          sy <= sy + 41'(y_d);
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (acc && cmd.opcode == OP_COMPUTE && in_grid) begin
            tgt_row <= cmd.row;
            tgt_col <= cmd.col;
            r0 <= r0_next;
            r1 <= r1_next;
            c0 <= c0_next;
            c1 <= c1_next;
            r  <= r0_next;
            c  <= c0_next;
            any <= 1'b0;
            nx  <= '0;
            ny  <= '0;
            nxy <= '0;
            sx  <= '0;
            sy  <= '0;
            sxx <= '0;
            sxy <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (c == c1) begin
            c <= c0;
            if (r == r1) begin
              state <= ST_DRAIN;
            end else begin
              r <= r + ROW_W'(1);
            end
          end else begin
            c <= c + COL_W'(1);
          end
        end
        ST_DRAIN: begin
          if (v2 && l2) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res.out_row          <= tgt_row;
          res.out_col          <= tgt_col;
          res.used_fallback    <= 1'b0;
          res.gradient_missing <= 1'b0;
          res.gradient         <= '0;
          if (mode == MODE_MINMAX) begin
            if (!any || spread <= 33'(min_spread)) begin
              res.gradient      <= fallback;
              res.used_fallback <= 1'b1;
              done  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              div_dvd   <= DVD_W'($signed({vdiff, 16'b0}));
              div_dvs   <= DVS_W'(spread);
              div_start <= 1'b1;
              state     <= ST_DIV_GRAD;
            end
          end else if (nx == '0 || ny == '0 || nxy == '0) begin
            res.gradient_missing <= 1'b1;
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            div_dvd   <= DVD_W'(sx);
            div_dvs   <= DVS_W'(nx);
            div_start <= 1'b1;
            state     <= ST_DIV_MX;
          end
        end
        ST_DIV_MX: begin
          if (div_done) begin
            mx        <= quot[31:0];
            div_dvd   <= DVD_W'(sy);
            div_dvs   <= DVS_W'(ny);
            div_start <= 1'b1;
            state     <= ST_DIV_MY;
          end
        end
        ST_DIV_MY: begin
          if (div_done) begin
            my        <= quot[31:0];
            div_dvd   <= DVD_W'(sxx);
            div_dvs   <= DVS_W'(nx);
            div_start <= 1'b1;
            state     <= ST_DIV_MXX;
          end
        end
        ST_DIV_MXX: begin
          if (div_done) begin
            mxx       <= quot[47:0];
            div_dvd   <= DVD_W'(sxy);
            div_dvs   <= DVS_W'(nxy);
            div_start <= 1'b1;
            state     <= ST_DIV_MXY;
          end
        end
        ST_DIV_MXY: begin
          if (div_done) begin
            mxy   <= quot[47:0];
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (den == '0) begin
            res.gradient      <= fallback;
            res.used_fallback <= 1'b1;
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            div_dvd   <= DVD_W'($signed({num, 16'b0}));
            div_dvs   <= den;
            div_start <= 1'b1;
            state     <= ST_DIV_GRAD;
          end
        end
        ST_DIV_GRAD: begin
          if (div_done) begin
            res.gradient <= sat32(quot);
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- design/wge_chk.sv -----
`include "window_gradient_engine_defines.svh"

module wge_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input wge_pkg::in_item_t  cmd,
  input logic               done,
  input wge_pkg::out_item_t res
);
  import wge_pkg::*;

  `WGE_ASSERT_NEXT(a_no_double_strobe, done, !done)
  `WGE_ASSERT_NEXT(a_no_result_after_accept, start && !busy, !done)
  `WGE_ASSERT_NOW(a_flags_exclusive, done, !(res.used_fallback && res.gradient_missing))
  `WGE_ASSERT_NOW(a_missing_zero, done && res.gradient_missing, res.gradient == '0)
  `WGE_ASSERT_NEXT(a_write_no_busy, start && !busy && cmd.opcode == OP_WRITE, !busy)
endmodule

bind window_gradient_engine wge_chk u_chk (.*);

// ----- sim/tb.sv -----
module tb;
  import wge_pkg::*;

  localparam int WINDOW_LATENCY = 700;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int ASK_SPAN = 10;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t cmd;
  logic done;
  out_item_t res;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  window_gradient_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow grid and register copies
  logic signed [31:0] grid_base [DEPTH];
  logic signed [31:0] grid_value [DEPTH];
  bit grid_bv [DEPTH];
  bit grid_vv [DEPTH];
  bit grid_set [DEPTH];
  bit cur_mode;
  int unsigned cur_rows;
  int unsigned cur_cols;
  int unsigned cur_half;
  longint cur_spread;
  logic signed [31:0] cur_fallback;

  out_item_t pending_gradients [$];
  int mismatches;
  longint cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] sat_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint quotient_q16(input longint num, input longint den);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    if (q > 40000) return 64'sd2147483647;
    if (q < -40000) return -64'sd2147483648;
    return q * 65536 + (r * 65536) / den;
  endfunction

  function automatic bit predict_gradient(input in_item_t it, output out_item_t o);
    int unsigned rows, cols, hw, r0, r1, c0, c1, idx;
    bit any;
    longint bmax, bmin, vmax, vmin, b, x, y;
    longint nx, ny, nxy, sx, sy, sxx, sxy, mx, my, mxx, mxy, den, num;
    rows = cur_rows == 0 ? 1 : (cur_rows > MAX_ROWS ? MAX_ROWS : cur_rows);
    cols = cur_cols == 0 ? 1 : (cur_cols > MAX_COLS ? MAX_COLS : cur_cols);
    hw = cur_half == 0 ? 1 : (cur_half > MAX_HALF_WIDTH ? MAX_HALF_WIDTH : cur_half);
    o = '0;
    if (it.row >= rows || it.col >= cols) return 0;
    o.out_row = it.row;
    o.out_col = it.col;
    r0 = it.row > hw ? it.row - hw : 0;
    c0 = it.col > hw ? it.col - hw : 0;
    r1 = it.row + hw < rows - 1 ? it.row + hw : rows - 1;
    c1 = it.col + hw < cols - 1 ? it.col + hw : cols - 1;
    any = 0;
    bmax = 0; bmin = 0; vmax = 0; vmin = 0;
    nx = 0; ny = 0; nxy = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
    for (int r = r0; r <= r1; r++) begin
      for (int c = c0; c <= c1; c++) begin
        idx = r * MAX_COLS + c;
        x = grid_base[idx];
        y = grid_value[idx];
        if (cur_mode == MODE_MINMAX) begin
          if (grid_bv[idx] && grid_vv[idx]) begin
            b = x;
            if (!any || b > bmax) begin bmax = b; vmax = y; end
            if (!any || b < bmin) begin bmin = b; vmin = y; end
            any = 1;
          end
        end else begin
          if (grid_bv[idx]) begin
            nx++; sx += x; sxx += (x * x) >>> 16;
          end
          if (grid_vv[idx]) begin
            ny++; sy += y;
          end
          if (grid_bv[idx] && grid_vv[idx]) begin
            nxy++; sxy += (x * y) >>> 16;
          end
        end
      end
    end
    if (cur_mode == MODE_MINMAX) begin
      if (!any || bmax - bmin <= cur_spread) begin
        o.gradient = cur_fallback;
        o.used_fallback = 1;
      end else begin
        o.gradient = sat_q16(((vmax - vmin) * 65536) / (bmax - bmin));
      end
    end else if (nx == 0 || ny == 0 || nxy == 0) begin
      o.gradient_missing = 1;
    end else begin
      mx = sx / nx; my = sy / ny; mxx = sxx / nx; mxy = sxy / nxy;
      den = mxx - ((mx * mx) >>> 16);
      num = mxy - ((mx * my) >>> 16);
      if (den == 0) begin
        o.gradient = cur_fallback;
        o.used_fallback = 1;
      end else begin
        o.gradient = sat_q16(quotient_q16(num, den));
      end
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_gradients.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result row %0d col %0d grad %h", res.out_row, res.out_col,
                   res.gradient);
      end else begin
        want = pending_gradients.pop_front();
        if (res.out_row !== want.out_row || res.out_col !== want.out_col ||
            res.gradient !== want.gradient || res.used_fallback !== want.used_fallback ||
            res.gradient_missing !== want.gradient_missing) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"row %0d col %0d: expected grad %h fb %b miss %b, ",
                      "got row %0d col %0d grad %h fb %b miss %b"},
                     want.out_row, want.out_col, want.gradient, want.used_fallback,
                     want.gradient_missing, res.out_row, res.out_col, res.gradient,
                     res.used_fallback, res.gradient_missing);
        end
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_q16();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return $urandom_range(0, 1 << 21) - (1 << 20);
    if (p < 8) return $urandom;
    if (p == 8) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  task automatic send(input in_item_t it, input bit gaps);
    out_item_t o;
    int g;
    int idx;
    start <= 1;
    cmd <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (it.opcode == OP_WRITE) begin
      idx = int'(it.row) * MAX_COLS + int'(it.col);
      grid_base[idx] = it.base_in;
      grid_value[idx] = it.value_in;
      grid_bv[idx] = it.base_present;
      grid_vv[idx] = it.value_present;
      grid_set[idx] = 1;
    end else if (predict_gradient(it, o)) begin
      pending_gradients.push_back(o);
    end
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic put_cell(input int r, input int c, input logic [31:0] b,
                          input logic [31:0] v, input bit bp, input bit vp, input bit gaps);
    in_item_t it;
    it.opcode = OP_WRITE;
    it.row = ROW_W'(r); it.col = COL_W'(c);
    it.base_in = b; it.value_in = v;
    it.base_present = bp; it.value_present = vp;
    send(it, gaps);
  endtask

  // write any cell of the window that has not been written yet
  task automatic cover_window(input int r, input int c);
    int rows, cols, hw, r0, r1, c0, c1;
    rows = cur_rows == 0 ? 1 : (cur_rows > MAX_ROWS ? MAX_ROWS : int'(cur_rows));
    cols = cur_cols == 0 ? 1 : (cur_cols > MAX_COLS ? MAX_COLS : int'(cur_cols));
    hw = cur_half == 0 ? 1 : (cur_half > MAX_HALF_WIDTH ? MAX_HALF_WIDTH : int'(cur_half));
    if (r >= rows || c >= cols) return;
    r0 = r > hw ? r - hw : 0;
    c0 = c > hw ? c - hw : 0;
    r1 = r + hw < rows - 1 ? r + hw : rows - 1;
    c1 = c + hw < cols - 1 ? c + hw : cols - 1;
    for (int i = r0; i <= r1; i++)
      for (int j = c0; j <= c1; j++)
        if (!grid_set[i * MAX_COLS + j])
          put_cell(i, j, rand_q16(), rand_q16(), $urandom_range(0, 9) != 0,
                   $urandom_range(0, 9) != 0, 0);
  endtask

  task automatic ask(input int r, input int c);
    in_item_t it;
    cover_window(r, c);
    it = '0;
    it.opcode = OP_COMPUTE;
    it.row = ROW_W'(r); it.col = COL_W'(c);
    it.base_in = $urandom; it.value_in = $urandom;
    it.base_present = 1'($urandom); it.value_present = 1'($urandom);
    send(it, 1);
  endtask

  task automatic settle();
    start <= 0;
    forever begin
      @(posedge clk);
      if (pending_gradients.size() == 0 && !busy) break;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 0;
    case (idx)
      REG_MODE: cur_mode = data[0];
      REG_ROWS: cur_rows = 32'(data[6:0]);
      REG_COLS: cur_cols = 32'(data[6:0]);
      REG_HALF: cur_half = 32'(data[3:0]);
      REG_SPREAD: cur_spread = 64'(data[30:0]);
      REG_FALLBACK: cur_fallback = data;
      default: ;
    endcase
  endtask

  task automatic configure(input bit m, input int r, input int c, input int h,
                           input logic [31:0] s, input logic [31:0] f);
    settle();
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_ROWS, 32'(r));
    write_reg(REG_COLS, 32'(c));
    write_reg(REG_HALF, 32'(h));
    write_reg(REG_SPREAD, s);
    write_reg(REG_FALLBACK, f);
  endtask

  task automatic test_directed_minmax();
    configure(0, 64, 64, 1, 0, 32'h1234_5678);
    // equal bases: ties and zero spread
    put_cell(0, 0, 32'h0001_0000, 32'h0000_1000, 1, 1, 1);
    put_cell(0, 1, 32'h0001_0000, 32'h0007_0000, 1, 1, 1);
    put_cell(1, 0, 32'h0001_0000, 32'hFFF0_0000, 1, 1, 1);
    put_cell(1, 1, 32'h0001_0000, 32'h0000_0000, 1, 1, 1);
    ask(0, 0);
    // full-range bases and values
    put_cell(63, 63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1);
    put_cell(63, 62, 32'h8000_0000, 32'h8000_0000, 1, 1, 1);
    put_cell(62, 63, 32'h0, 32'h0, 0, 1, 1);
    put_cell(62, 62, 32'h0, 32'h0, 1, 0, 1);
    ask(63, 63);
    // tiny spread, saturating quotient
    put_cell(0, 62, 32'h0, 32'h8000_0000, 1, 1, 1);
    put_cell(0, 63, 32'h1, 32'h7FFF_FFFF, 1, 1, 1);
    put_cell(1, 62, 32'h0, 32'h0, 0, 0, 1);
    put_cell(1, 63, 32'h0, 32'h0, 1, 0, 1);
    ask(0, 63);
    // nothing valid
    put_cell(63, 0, 32'h5, 32'h6, 0, 1, 1);
    put_cell(63, 1, 32'h5, 32'h6, 1, 0, 1);
    put_cell(62, 0, 32'h5, 32'h6, 0, 0, 1);
    put_cell(62, 1, 32'h5, 32'h6, 0, 1, 1);
    ask(63, 0);
  endtask

  task automatic test_directed_regression();
    configure(1, 64, 64, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    ask(0, 0);
    ask(63, 63);
    ask(0, 63);
    ask(63, 0);
  endtask

  task automatic test_grid_limits();
    configure(0, 1, 1, 0, 32'h0, 32'h7FFF_FFFF);
    ask(0, 0);
    ask(5, 0);
    ask(0, 5);
    configure(1, 0, 127, 15, 32'h0, 32'h0000_0001);
    ask(0, 63);
    ask(1, 10);
    ask(0, 0);
  endtask

  task automatic random_phase(input int items);
    int p;
    int rows, cols, ask_rows, ask_cols;
    rows = cur_rows == 0 ? 1 : (cur_rows > MAX_ROWS ? MAX_ROWS : int'(cur_rows));
    cols = cur_cols == 0 ? 1 : (cur_cols > MAX_COLS ? MAX_COLS : int'(cur_cols));
    ask_rows = rows < ASK_SPAN ? rows : ASK_SPAN;
    ask_cols = cols < ASK_SPAN ? cols : ASK_SPAN;
    for (int k = 0; k < items; k++) begin
      p = $urandom_range(0, 99);
      if (p < 55)
        put_cell($urandom_range(0, 63), $urandom_range(0, 63), rand_q16(), rand_q16(),
                 $urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0, 1);
      else if (p < 93 || (rows == MAX_ROWS && cols == MAX_COLS))
        ask($urandom_range(0, ask_rows - 1), $urandom_range(0, ask_cols - 1));
      else if (rows < MAX_ROWS)
        ask($urandom_range(rows, 63), $urandom_range(0, 63));
      else
        ask($urandom_range(0, 63), $urandom_range(cols, 63));
    end
  endtask

  task automatic test_random_minmax();
    configure(0, 64, 64, 1, 0, 32'h0);
    random_phase(180);
    configure(0, 20, 33, 3, 32'h0004_0000, 32'hDEAD_BEEF);
    random_phase(180);
    configure(0, 64, 64, 8, 32'h0100_0000, 32'h0001_0000);
    random_phase(130);
  endtask

  task automatic test_random_regression();
    configure(1, 64, 64, 1, 0, 32'h7FFF_FFFF);
    random_phase(220);
    configure(1, 7, 64, 2, 0, 32'h8000_0000);
    random_phase(180);
    configure(1, 64, 64, 8, 0, 32'h0000_4000);
    random_phase(110);
  endtask

  task automatic test_random_mixed();
    configure(0, 64, 2, 5, 32'h0000_0100, 32'h0);
    random_phase(130);
    configure(1, 1, 64, 4, 0, 32'hFFFF_0000);
    random_phase(130);
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    rst = 1;
    start = 0;
    cmd = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    cur_mode = 0; cur_rows = 64; cur_cols = 64; cur_half = 1;
    cur_spread = 0; cur_fallback = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed_minmax();
    test_directed_regression();
    test_grid_limits();
    test_random_minmax();
    test_random_regression();
    test_random_mixed();
    settle();
    repeat (WINDOW_LATENCY) @(posedge clk);
    mismatches += pending_gradients.size();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
